[rtl/bdod_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdod_pkg
// Shared widths, limits and the control bundle for the bit destuffing decoder.
// ----------------------------------------------------------------------------
package bdod_pkg;

   localparam int unsigned WORD_BITS    = 64;
   localparam int unsigned PAYLOAD_BITS = 49;
   localparam int unsigned RUN_LIMIT    = 5;

   localparam int unsigned SRC_CNT_W = $clog2(WORD_BITS + 1);
   localparam int unsigned DST_CNT_W = $clog2(PAYLOAD_BITS + 1);
   localparam int unsigned RUN_W     = $clog2(RUN_LIMIT);

   // result beat width, payload padded to whole bytes
   localparam int unsigned RSP_DATA_W = ((PAYLOAD_BITS + 7) / 8) * 8;

   // per-cycle controls from the sequencer to the cell rows
   typedef struct packed {
      logic load;       // load a fresh word, clear payload
      logic src_shift;  // advance source row by one bit
      logic pay_shift;  // push one bit into payload row
      logic pay_bit;    // bit pushed into payload row
      logic xfer;       // move finished payload to output register
   } ctrl_type;

endpackage
`default_nettype wire

[rtl/bit_destuff_order_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bit_destuff_order_decode
// HDLC-style bit destuffing of a 64-bit word into a 49-bit order record.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The input word is loaded into a row of 64 one-bit
// cells and shifted toward cell 0 one bit per cycle; a sequencer watches the
// head cell, counts runs of ones, drops the bit following five ones without
// looking at it, and pushes every kept bit into a 49-cell payload row. When
// the word runs out early the payload row is filled with zeros. A word is
// loaded, scanned until 49 payload bits are kept, with each dropped stuffing
// bit (at most nine) lengthening the scan, and then moved into the output
// register; a new word is taken only while the sequencer is idle. The
// output register is separate from the cell rows, so a new word is taken
// while a finished result still waits on rsp_tready; if that result is still
// waiting when the next scan ends, the sequencer holds and req_tready stays low.
// ----------------------------------------------------------------------------
module bit_destuff_order_decode (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: [63:0] encoded_word
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   // rsp_tdata: [31:0] stock_key, [32] is_sell, [40:33] quantity,
   //            [48:41] price_value, [55:49] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata
);

   import bdod_pkg::*;

   ctrl_type                ctrl;
   logic                    idle;
   logic                    start;
   logic                    out_free;
   logic [WORD_BITS-1:0]    src_bits;
   logic [PAYLOAD_BITS-1:0] pay_bits;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff, rsp_pay_in;

   assign start    = req_tvalid & idle;
   assign out_free = ~rsp_valid_ff | rsp_tready;

   bdod_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .head_bit (src_bits[0]),
      .out_free (out_free),
      .idle     (idle),
      .ctrl     (ctrl)
   );

   // source row: shifts toward cell 0, zero enters at the top
   for (genvar i = 0; i < WORD_BITS; i++) begin : g_src
      bdod_cell u_cell (
         .clock    (clock),
         .load     (ctrl.load),
         .load_bit (req_tdata[i]),
         .shift    (ctrl.src_shift),
         .shift_in ((i == WORD_BITS - 1) ? 1'b0 : src_bits[(i + 1) % WORD_BITS]),
         .bit_out  (src_bits[i])
      );
   end

   // payload row: kept bits enter at the top, first bit ends in cell 0
   for (genvar j = 0; j < PAYLOAD_BITS; j++) begin : g_pay
      bdod_cell u_cell (
         .clock    (clock),
         .load     (ctrl.load),
         .load_bit (1'b0),
         .shift    (ctrl.pay_shift),
         .shift_in ((j == PAYLOAD_BITS - 1) ? ctrl.pay_bit
                                            : pay_bits[(j + 1) % PAYLOAD_BITS]),
         .bit_out  (pay_bits[j])
      );
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pay_in   = rsp_pay_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.xfer) begin
         rsp_valid_in = 1'b1;
         rsp_pay_in   = pay_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pay_ff <= rsp_pay_in;
   end

   assign req_tready = idle;
   assign rsp_tvalid = rsp_valid_ff;
   // payload bit order matches the field layout; pad to whole bytes
   assign rsp_tdata  = {(RSP_DATA_W - PAYLOAD_BITS)'(0), rsp_pay_ff};

endmodule
`default_nettype wire

[rtl/bdod_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdod_cell
// One-bit shift cell: loads in parallel, takes its neighbor's bit, or holds.
// ----------------------------------------------------------------------------
module bdod_cell (
   input  wire logic clock,
   input  wire logic load,
   input  wire logic load_bit,
   input  wire logic shift,
   input  wire logic shift_in,
   output logic      bit_out
);

   logic bit_ff;
   logic bit_in;

   always_comb begin
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = shift_in;
      end else begin
         bit_in = bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;

endmodule
`default_nettype wire

[rtl/bdod_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdod_ctrl
// Scan sequencer: one encoded bit per cycle while scanning, tracks run of ones and stuffing.
// ----------------------------------------------------------------------------
module bdod_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              head_bit,
   input  wire logic              out_free,
   output logic                   idle,
   output bdod_pkg::ctrl_type     ctrl
);

   import bdod_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   localparam logic [SRC_CNT_W-1:0] SRC_END  = SRC_CNT_W'(WORD_BITS);
   localparam logic [DST_CNT_W-1:0] DST_LAST = DST_CNT_W'(PAYLOAD_BITS - 1);
   localparam logic [RUN_W-1:0]     RUN_LAST = RUN_W'(RUN_LIMIT - 1);

   logic [1:0]           state_ff, state_in;
   logic [SRC_CNT_W-1:0] src_cnt_ff, src_cnt_in;
   logic [DST_CNT_W-1:0] dst_cnt_ff, dst_cnt_in;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic                 skip_ff, skip_in;

   always_comb begin
      state_in   = state_ff;
      src_cnt_in = src_cnt_ff;
      dst_cnt_in = dst_cnt_ff;
      run_in     = run_ff;
      skip_in    = skip_ff;
      ctrl       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load  = 1'b1;
               src_cnt_in = '0;
               dst_cnt_in = '0;
               run_in     = '0;
               skip_in    = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (src_cnt_ff != SRC_END) begin
               ctrl.src_shift = 1'b1;
               src_cnt_in     = src_cnt_ff + 1'b1;
               if (skip_ff) begin
                  // stuffing bit: dropped unchecked
                  skip_in = 1'b0;
               end else begin
                  ctrl.pay_shift = 1'b1;
                  ctrl.pay_bit   = head_bit;
                  if (!head_bit) begin
                     run_in = '0;
                  end else if (run_ff == RUN_LAST) begin
                     run_in  = '0;
                     skip_in = 1'b1;
                  end else begin
                     run_in = run_ff + 1'b1;
                  end
               end
            end else begin
               // word exhausted: pad remaining payload with zeros
               ctrl.pay_shift = 1'b1;
               ctrl.pay_bit   = 1'b0;
            end
            if (ctrl.pay_shift) begin
               dst_cnt_in = dst_cnt_ff + 1'b1;
               if (dst_cnt_ff == DST_LAST) begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               ctrl.xfer = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      src_cnt_ff <= src_cnt_in;
      dst_cnt_ff <= dst_cnt_in;
      run_ff     <= run_in;
      skip_ff    <= skip_in;
   end

   assign idle = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

[rtl/bdod_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdod_checker
// Port-level checks for the bit destuffing decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bdod_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   // stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // stalled result data holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp data changed while stalled");

   // pad bits above the payload are zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:49] == 7'd0)
      else $error("rsp pad bits not zero");

   // one word at a time: no new beat right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted during scan");

   // a result never appears the cycle after its word was taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("rsp beat without scan time");

endmodule

bind bit_destuff_order_decode bdod_checker u_bdod_checker (.*);
`default_nettype wire

[tb/sv/bit_destuff_order_decode_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_destuff_order_decode_test
// Self-checking bench for the bit destuffing order decoder. A directed table of
// words is sent first, then a random part of noise, dense and sparse words. Each
// result beat is checked field by field against a hand-read expectation or a
// local model of the destuff scan.
// ----------------------------------------------------------------------------
module bit_destuff_order_decode_test;
   import bdod_pkg::*;

   localparam int RANDOM_WORDS  = 550;
   localparam int CALM_TAIL     = 100;   // last words sent with no idling
   localparam int LONG_HOLD     = 400;   // one long rsp_tready hold-off
   localparam int HOLD_AT_WORD  = 150;
   localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on either side
   localparam int DRAIN_CYCLES  = 80;    // settle time after the last result beat
   localparam int REPORT_LIMIT  = 10;
   localparam int EXPECT_DEPTH  = 16;    // well above the words in flight

   // decoded order record, as it sits in rsp_tdata
   typedef struct packed {
      logic [6:0]  pad;
      logic [7:0]  price_value;
      logic [7:0]  quantity;
      logic        is_sell;
      logic [31:0] stock_key;
   } order_fields_type;

   // directed row: word plus a hand-read expectation when typed is set
   typedef struct packed {
      logic [63:0] word;
      logic        typed;
      logic [31:0] key;
      logic        sell;
      logic [7:0]  qty;
      logic [7:0]  price;
   } directed_row_type;

   localparam int N_DIRECTED = 18;

   directed_row_type directed_words [N_DIRECTED] = '{
      // all zeros: nothing set
      '{64'h0000_0000_0000_0000, 1'b1, 32'h0000_0000, 1'b0, 8'h00, 8'h00},
      // all ones: every sixth bit dropped, payload still all ones
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF},
      // ones only above the payload reach: ignored
      '{64'hFFFE_0000_0000_0000, 1'b1, 32'h0000_0000, 1'b0, 8'h00, 8'h00},
      // top payload bit alone
      '{64'h0001_0000_0000_0000, 1'b1, 32'h0000_0000, 1'b0, 8'h00, 8'h80},
      // sell flag alone
      '{64'h0000_0001_0000_0000, 1'b1, 32'h0000_0000, 1'b1, 8'h00, 8'h00},
      // five ones, the zero after them is the stuffing bit
      '{64'h0000_0000_0000_001F, 1'b1, 32'h0000_001F, 1'b0, 8'h00, 8'h00},
      // stuffing bit is a one and still dropped
      '{64'h0000_0000_0000_003F, 1'b1, 32'h0000_001F, 1'b0, 8'h00, 8'h00},
      // only encoded bit 63
      '{64'h8000_0000_0000_0000, 1'b1, 32'h0000_0000, 1'b0, 8'h00, 8'h00},
      // the rest goes through the model
      '{64'h0000_0000_0000_007F, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0},
      '{64'h0000_01FE_0000_0000, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0},
      '{64'h5555_5555_5555_5555, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0},
      // run of five ones ending at the top bit
      '{64'hF800_0000_0000_0000, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0},
      '{64'hF7DF_7DF7_DF7D_F7DF, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0},
      '{64'hFFFF_FFFF_0000_0000, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0},
      '{64'h0000_0000_FFFF_FFFF, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0},
      '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 32'h0, 1'b0, 8'h0, 8'h0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;         // [63:0] encoded_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;              // [31:0] key, [32] sell, [40:33] qty,
                                        // [48:41] price, [55:49] zero

   // decodes waiting for their beat, oldest at expect_rd
   order_fields_type expect_ring [EXPECT_DEPTH];
   int  expect_wr = 0;
   int  expect_rd = 0;
   order_fields_type got_order, want_order;
   int  mismatch_count = 0;
   int  words_sent = 0;
   int  quiet_cycles = 0;
   bit  idling_on = 1'b1;
   logic hold_go = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;

   bit_destuff_order_decode DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Scan the word LSB first; after five ones in a row the next encoded
   // bit is skipped whatever it holds. Stops at 49 kept bits or 64 used.
   function automatic order_fields_type decode_order(input logic [63:0] word);
      logic [48:0]      payload;
      int               src;
      int               dst;
      int               ones_run;
      order_fields_type fields;
      payload  = '0;
      src      = 0;
      dst      = 0;
      ones_run = 0;
      while (src < int'(WORD_BITS) && dst < int'(PAYLOAD_BITS)) begin
         payload[dst] = word[src];
         dst++;
         if (word[src]) begin
            ones_run++;
            if (ones_run == int'(RUN_LIMIT)) begin
               ones_run = 0;
               src++;
            end
         end else begin
            ones_run = 0;
         end
         src++;
      end
      fields.pad         = '0;
      fields.stock_key   = payload[31:0];
      fields.is_sell     = payload[32];
      fields.quantity    = payload[40:33];
      fields.price_value = payload[48:41];
      return fields;
   endfunction

   // A mix of plain noise, words heavy in ones and sparse words built from short
   // runs of ones, so runs and stuffing bits land all over the field boundaries.
   function automatic logic [63:0] random_word();
      logic [63:0] word;
      int          pos;
      int          len;
      case ($urandom_range(0, 9))
         0, 1, 2: word = {$urandom, $urandom};
         3, 4, 5: word = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
         6, 7, 8: begin
            word = '0;
            repeat ($urandom_range(3, 10)) begin
               pos = $urandom_range(0, 63);
               len = $urandom_range(3, 8);
               for (int i = 0; i < len; i++)
                  if (pos + i < 64) word[pos + i] = 1'b1;
            end
         end
         default: word = {$urandom, $urandom} & {$urandom, $urandom};
      endcase
      return word;
   endfunction

   // Offer one word, optionally after an idle burst, and queue its
   // expected decode on the edge where the beat is taken.
   task automatic send_word(input logic [63:0] word, input order_fields_type want);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expect_ring[expect_wr % EXPECT_DEPTH] = want;
      expect_wr++;
      words_sent++;
      if (words_sent == HOLD_AT_WORD) hold_go <= 1'b1;
   endtask

   // Receiver: random stall bursts, plus one long hold-off so the output
   // register and the scan both fill and req_tready drops.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: oldest expectation first, pad bits included.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_order = rsp_tdata;
         if (expect_wr == expect_rd) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result beat %h", rsp_tdata);
         end else begin
            want_order = expect_ring[expect_rd % EXPECT_DEPTH];
            expect_rd++;
            if (got_order.stock_key   !== want_order.stock_key   ||
                got_order.is_sell     !== want_order.is_sell     ||
                got_order.quantity    !== want_order.quantity    ||
                got_order.price_value !== want_order.price_value ||
                got_order.pad         !== want_order.pad) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: exp key=%h sell=%b qty=%h price=%h pad=%h",
                           want_order.stock_key, want_order.is_sell,
                           want_order.quantity, want_order.price_value, want_order.pad,
                           " got key=%h sell=%b qty=%h price=%h pad=%h",
                           got_order.stock_key, got_order.is_sell,
                           got_order.quantity, got_order.price_value, got_order.pad);
            end
         end
      end
   end

   // Watchdog: no beat on either side for too long means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      order_fields_type hand_read;
      logic [63:0]      word;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[i]) begin
         if (directed_words[i].typed) begin
            hand_read.pad         = '0;
            hand_read.stock_key   = directed_words[i].key;
            hand_read.is_sell     = directed_words[i].sell;
            hand_read.quantity    = directed_words[i].qty;
            hand_read.price_value = directed_words[i].price;
         end else begin
            hand_read = decode_order(directed_words[i].word);
         end
         send_word(directed_words[i].word, hand_read);
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - CALM_TAIL) idling_on = 1'b0;
         word = random_word();
         send_word(word, decode_order(word));
      end
      req_tvalid <= 1'b0;

      while (expect_wr != expect_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/bdod_pkg.sv
rtl/bdod_cell.sv
rtl/bdod_ctrl.sv
rtl/bit_destuff_order_decode.sv
rtl/bdod_checker.sv
tb/sv/bit_destuff_order_decode_test.sv
